@@ rtl/fct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

    localparam int DEF_ENTRIES = 64;

    localparam int ADDR_W  = 64;
    localparam int IDENT_W = 32;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;

    localparam logic [6:0]  MAX_SETS_RST = 7'd64;
    localparam logic [15:0] TTL_RST      = 16'd60;
    localparam logic [11:0] GC_INT_RST   = 12'd10;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_MAX_SETS = 2'd0;
    localparam logic [1:0] CFG_TTL      = 2'd1;
    localparam logic [1:0] CFG_GC_INT   = 2'd2;

    typedef enum logic [1:0] {
        OP_FIND    = 2'd0,
        OP_TICK    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_CREATED = 2'd1,
        ST_FULL    = 2'd2,
        ST_DONE    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_SWEEP,
        S_REL
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]  src_high;
        logic [ADDR_W-1:0]  src_low;
        logic [ADDR_W-1:0]  dst_high;
        logic [ADDR_W-1:0]  dst_low;
        logic [IDENT_W-1:0] ident;
    } t_key;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] expiry;
        t_key              key;
    } t_entry;

    typedef struct packed {
        logic hit;
        logic expired;
    } t_cmp_res;

endpackage

`default_nettype wire

@@ rtl/fct_ctx_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fct_ctx_mem
    import fct_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(ENTRIES)-1:0] i_waddr,
    input  wire t_entry                     i_wdata,
    input  wire logic [$clog2(ENTRIES)-1:0] i_raddr,
    output t_entry                          o_rdata
);

    t_entry r_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/fct_cmp_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fct_cmp_unit
    import fct_pkg::*;
(
    input  wire t_entry              i_entry,
    input  wire t_key                i_key,
    input  wire logic [TIME_W-1:0]   i_now,
    input  wire logic [15:0]         i_ttl,
    output t_cmp_res                 o_res,
    output logic [TIME_W-1:0]        o_expiry
);

    logic [TIME_W:0] sum;

    assign o_res.hit     = i_entry.valid && (i_entry.key == i_key);
    assign o_res.expired = i_entry.valid && (i_entry.expiry < i_now);

    // saturate the new expiry at the top of the time range
    assign sum      = {1'b0, i_now} + {{(TIME_W-15){1'b0}}, i_ttl};
    assign o_expiry = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

endmodule

`default_nettype wire

@@ rtl/fragment_context_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel | Ports                                                      | Beat
// --------+------------------------------------------------------------+-----------------
// command | i_operation, i_src_*, i_dst_*, i_frag_id, i_release_index  | start && !busy
// result  | o_status, o_entry_index, o_expired_count                   | o_strobe, 1 cycle
// config  | i_cfg_we, i_cfg_index, i_cfg_wdata                         | i_cfg_we
//
// Scan: one context memory is scanned one entry per cycle through a single compare unit.
// find_or_create scans the whole table but ends early on a hit, a tick with a sweep scans
// the whole table, a release reads only its one entry, and a tick without sweep or a no-op
// answers straight from idle; the result beat is registered.
// Reset: a clearing pass that wipes every entry, with busy high, follows reset; config is taken.
// Stalls: none; the receiver cannot stall and each result beat lasts one cycle.

module fragment_context_table
    import fct_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_operation,
    input  wire logic [ADDR_W-1:0]  i_src_high,
    input  wire logic [ADDR_W-1:0]  i_src_low,
    input  wire logic [ADDR_W-1:0]  i_dst_high,
    input  wire logic [ADDR_W-1:0]  i_dst_low,
    input  wire logic [IDENT_W-1:0] i_frag_id,
    input  wire logic [5:0]         i_release_index,

    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output logic [5:0]              o_entry_index,
    output logic [6:0]              o_expired_count,

    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int LIVE_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] SCAN_END = IDX_W'(ENTRIES - 1);

    // configuration
    logic [6:0]  r_max_sets;
    logic [15:0] r_ttl;
    logic [11:0] r_gc_int;

    // sequencer state
    t_state             r_state,      n_state;
    logic [IDX_W-1:0]   r_chk_idx,    n_chk_idx;
    logic               r_free_found, n_free_found;
    logic [IDX_W-1:0]   r_free_idx,   n_free_idx;
    t_key               r_key,        n_key;
    logic [TIME_W-1:0]  r_seconds,    n_seconds;
    logic [11:0]        r_countdown,  n_countdown;
    logic [LIVE_W-1:0]  r_live,       n_live;
    logic [LIVE_W-1:0]  r_freed,      n_freed;

    // result register
    logic               r_out_valid,  n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [5:0]         r_out_index,  n_out_index;
    logic [6:0]         r_out_freed,  n_out_freed;

    // memory and compare unit
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_entry             mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    t_entry             mem_rdata;
    t_cmp_res           cmp_res;
    logic [TIME_W-1:0]  new_expiry;

    logic [12:0]        tick_count;
    logic [IDX_W-1:0]   alloc_idx;
    logic [LIVE_W-1:0]  sweep_freed;

    fct_ctx_mem #(
        .ENTRIES (ENTRIES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    fct_cmp_unit u_cmp (
        .i_entry  (mem_rdata),
        .i_key    (r_key),
        .i_now    (r_seconds),
        .i_ttl    (r_ttl),
        .o_res    (cmp_res),
        .o_expiry (new_expiry)
    );

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_out_valid;
    assign o_status        = r_out_status;
    assign o_entry_index   = r_out_index;
    assign o_expired_count = r_out_freed;

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_sets <= MAX_SETS_RST;
            r_ttl      <= TTL_RST;
            r_gc_int   <= GC_INT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_SETS: r_max_sets <= i_cfg_wdata[6:0];
                CFG_TTL:      r_ttl      <= i_cfg_wdata[15:0];
                CFG_GC_INT:   r_gc_int   <= i_cfg_wdata[11:0];
                default:      ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_chk_idx    <= '0;
            r_free_found <= 1'b0;
            r_seconds    <= '0;
            r_countdown  <= '0;
            r_live       <= '0;
            r_freed      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_chk_idx    <= n_chk_idx;
            r_free_found <= n_free_found;
            r_seconds    <= n_seconds;
            r_countdown  <= n_countdown;
            r_live       <= n_live;
            r_freed      <= n_freed;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_free_idx   <= n_free_idx;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        r_out_freed  <= n_out_freed;
    end

    assign tick_count  = {1'b0, r_countdown} + 13'd1;
    assign alloc_idx   = r_free_found ? r_free_idx : r_chk_idx;
    assign sweep_freed = r_freed + LIVE_W'(cmp_res.expired);

    always_comb begin
        n_state      = r_state;
        n_chk_idx    = r_chk_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_key        = r_key;
        n_seconds    = r_seconds;
        n_countdown  = r_countdown;
        n_live       = r_live;
        n_freed      = r_freed;
        n_out_valid  = 1'b0;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        n_out_freed  = r_out_freed;

        mem_we       = 1'b0;
        mem_waddr    = r_chk_idx;
        mem_wdata    = mem_rdata;
        mem_raddr    = r_chk_idx + 1'b1;

        unique case (r_state)
            S_CLEAR: begin
                // wipe one entry per cycle
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (r_chk_idx == SCAN_END) begin
                    n_chk_idx = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_chk_idx = r_chk_idx + 1'b1;
                end
            end

            S_IDLE: begin
                mem_raddr = '0;
                if (start) begin
                    n_out_status = ST_DONE;
                    n_out_index  = '0;
                    n_out_freed  = '0;
                    unique case (t_op'(i_operation))
                        OP_FIND: begin
                            n_key.src_high = i_src_high;
                            n_key.src_low  = i_src_low;
                            n_key.dst_high = i_dst_high;
                            n_key.dst_low  = i_dst_low;
                            n_key.ident    = i_frag_id;
                            n_chk_idx      = '0;
                            n_free_found   = 1'b0;
                            n_state        = S_FIND;
                        end
                        OP_TICK: begin
                            // advance the clock first, then count toward the sweep
                            n_seconds = (r_seconds == '1) ? r_seconds : r_seconds + 1'b1;
                            if (tick_count >= {1'b0, r_gc_int}) begin
                                n_countdown = '0;
                                n_freed     = '0;
                                n_chk_idx   = '0;
                                n_state     = S_SWEEP;
                            end else begin
                                n_countdown = tick_count[11:0];
                                n_out_valid = 1'b1;
                            end
                        end
                        OP_RELEASE: begin
                            if (32'(i_release_index) < ENTRIES) begin
                                mem_raddr = IDX_W'(i_release_index);
                                n_chk_idx = IDX_W'(i_release_index);
                                n_state   = S_REL;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        OP_NOP: begin
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end

            S_FIND: begin
                if (cmp_res.hit) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_FOUND;
                    n_out_index  = 6'(r_chk_idx);
                    n_chk_idx    = '0;
                    n_state      = S_IDLE;
                end else begin
                    // remember the lowest free entry
                    if (!mem_rdata.valid && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_chk_idx;
                    end
                    if (r_chk_idx == SCAN_END) begin
                        n_out_valid = 1'b1;
                        if ((r_free_found || !mem_rdata.valid) &&
                            (32'(r_live) < 32'(r_max_sets))) begin
                            mem_we           = 1'b1;
                            mem_waddr        = alloc_idx;
                            mem_wdata.valid  = 1'b1;
                            mem_wdata.expiry = new_expiry;
                            mem_wdata.key    = r_key;
                            n_live           = r_live + 1'b1;
                            n_out_status     = ST_CREATED;
                            n_out_index      = 6'(alloc_idx);
                        end else begin
                            n_out_status = ST_FULL;
                            n_out_index  = '0;
                        end
                        n_chk_idx = '0;
                        n_state   = S_IDLE;
                    end else begin
                        n_chk_idx = r_chk_idx + 1'b1;
                    end
                end
            end

            S_SWEEP: begin
                // drop each live entry whose expiry is before now
                if (cmp_res.expired) begin
                    mem_we          = 1'b1;
                    mem_wdata.valid = 1'b0;
                    n_live          = r_live - 1'b1;
                end
                n_freed = sweep_freed;
                if (r_chk_idx == SCAN_END) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_DONE;
                    n_out_index  = '0;
                    n_out_freed  = 7'(sweep_freed);
                    n_chk_idx    = '0;
                    n_state      = S_IDLE;
                end else begin
                    n_chk_idx = r_chk_idx + 1'b1;
                end
            end

            S_REL: begin
                if (mem_rdata.valid) begin
                    mem_we          = 1'b1;
                    mem_wdata.valid = 1'b0;
                    n_live          = r_live - 1'b1;
                end
                n_out_valid  = 1'b1;
                n_out_status = ST_DONE;
                n_out_index  = '0;
                n_out_freed  = '0;
                n_chk_idx    = '0;
                n_state      = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/fct_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fct_checker
    import fct_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_strobe,
    input wire logic [1:0] o_status,
    input wire logic [5:0] o_entry_index,
    input wire logic [6:0] o_expired_count
);

    // reset starts the clearing pass and drops any pending beat
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_strobe)
        else $error("no clearing pass after reset");

    // a taken command either keeps the block busy or returns its beat at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_strobe)
        else $error("command taken but neither busy nor answered");

    // a result beat only follows a taken command or ongoing work
    a_no_stray_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy) || $past(start))
        else $error("result beat without a command");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == ST_FULL || o_status == ST_DONE) |-> o_entry_index == '0)
        else $error("entry index set on full or done");

    a_count_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status != ST_DONE |-> o_expired_count == '0)
        else $error("expired count set outside a tick");

endmodule

bind fragment_context_table fct_checker u_fct_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_status        (o_status),
    .o_entry_index   (o_entry_index),
    .o_expired_count (o_expired_count)
);

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import fct_pkg::*;

    localparam int TABLE_SIZE  = DEF_ENTRIES;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int POOL_KEYS   = 48;

    // Expected outcome of one command beat.
    typedef struct {
        t_status    status;
        logic [5:0] index;
        logic [6:0] freed;
    } t_ctx_result;

    // Drive every input to a known value from time zero.
    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               start           = 1'b0;
    logic               busy;
    logic [1:0]         i_operation     = OP_NOP;
    logic [ADDR_W-1:0]  i_src_high      = '0;
    logic [ADDR_W-1:0]  i_src_low       = '0;
    logic [ADDR_W-1:0]  i_dst_high      = '0;
    logic [ADDR_W-1:0]  i_dst_low       = '0;
    logic [IDENT_W-1:0] i_frag_id       = '0;
    logic [5:0]         i_release_index = '0;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic [5:0]         o_entry_index;
    logic [6:0]         o_expired_count;
    logic               i_cfg_we        = 1'b0;
    logic [1:0]         i_cfg_index     = CFG_MAX_SETS;
    logic [CFG_W-1:0]   i_cfg_wdata     = '0;

    fragment_context_table #(.ENTRIES(TABLE_SIZE)) DUT (.*);

    always #1 i_clk = ~i_clk;

    // Shadow copy of the context table and its registers.
    logic        ctx_live   [TABLE_SIZE];
    t_key        ctx_key    [TABLE_SIZE];
    int unsigned ctx_expiry [TABLE_SIZE];
    int unsigned now_sec;
    int unsigned sweep_ticks;
    int unsigned live_total;
    int unsigned cfg_max_sets;
    int unsigned cfg_ttl;
    int unsigned cfg_gc;

    t_ctx_result pending_results[$];
    t_key        key_pool[POOL_KEYS];

    int sender_idle_pct = 0;
    int cycle_count     = 0;
    int n_errors        = 0;
    int n_beats         = 0;
    int n_results       = 0;
    int n_created       = 0;
    int n_found         = 0;
    int n_full          = 0;
    int n_swept         = 0;
    int n_cfg_writes    = 0;

    // Apply one command to the shadow table and return what the block must answer.
    function automatic t_ctx_result apply_command(t_op op, t_key key, logic [5:0] rel);
        t_ctx_result r;
        int          hit;
        int unsigned cap;
        int unsigned exp_sec;
        int unsigned cnt;
        r.status = ST_DONE;
        r.index  = '0;
        r.freed  = '0;
        case (op)
            OP_FIND: begin
                hit = -1;
                for (int i = 0; i < TABLE_SIZE; i++) begin
                    if (hit < 0 && ctx_live[i] && ctx_key[i] == key)
                        hit = i;
                end
                if (hit >= 0) begin
                    r.status = ST_FOUND;
                    r.index  = 6'(hit);
                    n_found++;
                end else begin
                    cap = (cfg_max_sets < TABLE_SIZE) ? cfg_max_sets : TABLE_SIZE;
                    r.status = ST_FULL;
                    if (live_total < cap) begin
                        // claim the lowest free slot
                        for (int i = 0; i < TABLE_SIZE; i++) begin
                            if (hit < 0 && !ctx_live[i])
                                hit = i;
                        end
                        exp_sec = now_sec + cfg_ttl;
                        if (exp_sec < now_sec)
                            exp_sec = 32'hFFFF_FFFF;
                        ctx_live[hit]   = 1'b1;
                        ctx_key[hit]    = key;
                        ctx_expiry[hit] = exp_sec;
                        live_total++;
                        r.status = ST_CREATED;
                        r.index  = 6'(hit);
                        n_created++;
                    end else begin
                        n_full++;
                    end
                end
            end
            OP_TICK: begin
                if (now_sec != 32'hFFFF_FFFF)
                    now_sec++;
                cnt = sweep_ticks + 1;
                if (cnt >= cfg_gc) begin
                    for (int i = 0; i < TABLE_SIZE; i++) begin
                        if (ctx_live[i] && ctx_expiry[i] < now_sec) begin
                            ctx_live[i] = 1'b0;
                            live_total--;
                            r.freed++;
                        end
                    end
                    sweep_ticks = 0;
                    n_swept += r.freed;
                end else begin
                    sweep_ticks = cnt & 12'hFFF;
                end
            end
            OP_RELEASE: begin
                if (ctx_live[rel]) begin
                    ctx_live[rel] = 1'b0;
                    live_total--;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_key random_key();
        t_key k;
        k.src_high = {$urandom, $urandom};
        k.src_low  = {$urandom, $urandom};
        k.dst_high = {$urandom, $urandom};
        k.dst_low  = {$urandom, $urandom};
        k.ident    = $urandom;
        return k;
    endfunction

    // A pool key with one bit flipped: equal in all but one place.
    function automatic t_key near_key(t_key base);
        t_key k;
        int   pos;
        k   = base;
        pos = $urandom_range($bits(t_key) - 1);
        k[pos] = ~k[pos];
        return k;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH result %0d: %s got %0d want %0d", n_results, what, got, want);
        n_errors++;
    endtask

    // Present one command; start is left high so back-to-back beats need no toggle.
    task automatic send_cmd(t_op op, t_key key, logic [5:0] rel);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_operation     <= op;
        i_src_high      <= key.src_high;
        i_src_low       <= key.src_low;
        i_dst_high      <= key.dst_high;
        i_dst_low       <= key.dst_low;
        i_frag_id       <= key.ident;
        i_release_index <= rel;
        // busy read right after the edge still holds its value at the edge
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_command(op, key, rel));
        n_beats++;
    endtask

    // Drop start and hold until every expected result is back and the block is idle.
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all three registers; the block must be idle.
    task automatic write_config(int unsigned max_sets, int unsigned ttl, int unsigned gc);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAX_SETS;
        i_cfg_wdata <= CFG_W'(max_sets);
        @(posedge i_clk);
        i_cfg_index <= CFG_TTL;
        i_cfg_wdata <= CFG_W'(ttl);
        @(posedge i_clk);
        i_cfg_index <= CFG_GC_INT;
        i_cfg_wdata <= CFG_W'(gc);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_max_sets = max_sets & 32'h7F;
        cfg_ttl      = ttl & 32'hFFFF;
        cfg_gc       = gc & 32'hFFF;
        n_cfg_writes += 3;
    endtask

    // Result checker: the receiver never stalls, so every strobe is a beat.
    always @(posedge i_clk) begin : result_check
        t_ctx_result want;
        if (o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_entry_index !== want.index)
                    report_mismatch("entry_index", o_entry_index, want.index);
                if (o_expired_count !== want.freed)
                    report_mismatch("expired_count", o_expired_count, want.freed);
            end
            n_results++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // Default registers: create, hit, near miss, release, no-op, first sweep.
    task automatic test_basic_lookup();
        t_key zeros;
        t_key ones;
        t_key ones_near;
        zeros     = '0;
        ones      = '1;
        ones_near = ones;
        ones_near.ident[0] = 1'b0;
        send_cmd(OP_FIND, zeros, '0);
        send_cmd(OP_FIND, ones, '1);
        send_cmd(OP_FIND, zeros, '1);
        send_cmd(OP_FIND, ones_near, '0);
        send_cmd(OP_NOP, random_key(), 6'($urandom_range(63)));
        send_cmd(OP_RELEASE, random_key(), 6'd63);   // free slot: ignored
        send_cmd(OP_RELEASE, random_key(), 6'd1);
        send_cmd(OP_FIND, ones, '0);                 // reuses the lowest free slot
        repeat (10) send_cmd(OP_TICK, random_key(), 6'($urandom_range(63)));
    endtask

    // Register extremes: capacity of one and zero, zero lifetime, sweep on every tick.
    task automatic test_register_limits();
        t_key zeros;
        t_key ones;
        zeros = '0;
        ones  = '1;
        write_config(1, 0, 1);
        send_cmd(OP_FIND, random_key(), '0);         // already over capacity
        for (int i = 0; i < 3; i++)
            send_cmd(OP_RELEASE, random_key(), 6'(i));
        send_cmd(OP_FIND, zeros, '0);                // expires the same second
        send_cmd(OP_TICK, zeros, '0);
        write_config(0, 16'hFFFF, 0);
        send_cmd(OP_FIND, ones, '0);
        send_cmd(OP_TICK, ones, '1);
        write_config(127, 16'hFFFF, 12'hFFF);
        send_cmd(OP_FIND, ones, '1);
        send_cmd(OP_TICK, ones, '0);
    endtask

    // Mostly well-formed traffic over a small key pool so hits, fills and expiries recur.
    task automatic run_traffic(int items, int fresh_pct);
        int         sel;
        t_op        op;
        t_key       key;
        logic [5:0] rel;
        for (int i = 0; i < POOL_KEYS; i++)
            key_pool[i] = (i % 4 == 3) ? near_key(key_pool[i - 1]) : random_key();
        for (int n = 0; n < items; n++) begin
            sel = $urandom_range(99);
            key = random_key();
            rel = 6'($urandom_range(63));
            if (sel < 55) begin
                op  = OP_FIND;
                sel = $urandom_range(99);
                if (sel >= fresh_pct + 15)
                    key = key_pool[$urandom_range(POOL_KEYS - 1)];
                else if (sel >= fresh_pct)
                    key = near_key(key_pool[$urandom_range(POOL_KEYS - 1)]);
            end else if (sel < 80) begin
                op = OP_TICK;
            end else if (sel < 95) begin
                op = OP_RELEASE;
                if (live_total != 0 && $urandom_range(99) < 70) begin
                    do rel = 6'($urandom_range(63)); while (!ctx_live[rel]);
                end
            end else begin
                op = OP_NOP;
            end
            send_cmd(op, key, rel);
        end
    endtask

    task automatic test_random_traffic();
        sender_idle_pct = 33;
        write_config(64, 5, 3);
        run_traffic(200, 10);
        write_config($urandom_range(1, 12), $urandom_range(0, 20), 1);
        run_traffic(200, 10);
        sender_idle_pct = 86;
        write_config(127, 16'hFFFF, 3600);            // fill the table, then overflow
        run_traffic(200, 40);
        write_config(1, 0, 2);
        run_traffic(200, 10);
        sender_idle_pct = 0;
        write_config($urandom_range(1, 64), $urandom_range(0, 40), $urandom_range(1, 16));
        run_traffic(200, 10);
        // upper write-data bits beyond each register's width must be dropped
        write_config({9'($urandom), 7'd64}, 12, {4'($urandom), 12'd2});
        run_traffic(200, 10);
    endtask

    initial begin
        foreach (ctx_live[i])
            ctx_live[i] = 1'b0;
        now_sec      = 0;
        sweep_ticks  = 0;
        live_total   = 0;
        cfg_max_sets = MAX_SETS_RST;
        cfg_ttl      = TTL_RST;
        cfg_gc       = GC_INT_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_lookup();
        test_register_limits();
        test_random_traffic();

        drain();
        // a find or sweep scans the whole table; allow that long for stray beats
        repeat (2 * TABLE_SIZE + 8) @(posedge i_clk);

        $display("covered %0d command beats, %0d register writes, %0d results checked",
                 n_beats, n_cfg_writes, n_results);
        $display("contexts created %0d, found %0d, table full %0d, freed by sweeps %0d",
                 n_created, n_found, n_full, n_swept);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule
